@@ design/graph_bfs_dfs_engine_unit_assert.svh @@
// Assertion macros used by the port checker.
`ifndef GRAPH_BFS_DFS_ENGINE_UNIT_ASSERT_SVH
`define GRAPH_BFS_DFS_ENGINE_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GBD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GBD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

@@ design/gbd_pkg.sv @@
// ---------------------------------------------------------------------------
// Graph traversal engine package
// Shared payload types, function codes and sizing constants.
// ---------------------------------------------------------------------------
package gbd_pkg;
  localparam int unsigned MaxVertices = 32;
  localparam int unsigned MaxDegree   = 8;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_FIND   = 3'd2,
    FUNC_BFS    = 3'd3,
    FUNC_DFS    = 3'd4
  } func_e;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic [4:0] visited_vertex;
    logic       last_result;
    logic       link_hit;
    logic [1:0] status_code;
  } out_item_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic       reject;
    logic [1:0] reject_status;
    logic [2:0] func;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
  } cmd_t;
endpackage

@@ design/graph_bfs_dfs_engine_unit.sv @@
// ---------------------------------------------------------------------------
// Graph BFS/DFS engine
// Neighbor-list graph store with link commands and traversals.
// ---------------------------------------------------------------------------
// channel | direction | handshake
// cfg     | in        | cfg_we_i, cfg_wdata_i
// in      | in        | in_valid_i / in_ready_o
// out     | out       | out_valid_o / out_ready_i
// Link commands scan one list of the neighbor memory newest first, alternating
// a read state and a check state per entry; a remove then shifts the later
// entries down one by one.
// A traversal pops each vertex, emits it and checks each of its neighbor entries.
// Reset clears counts and visit bits at once; no clearing pass.
// Output stalls hold the back end; the two-entry queue keeps the front open until it fills.
module graph_bfs_dfs_engine_unit #(
  parameter int unsigned MAX_VERTICES = gbd_pkg::MaxVertices,
  parameter int unsigned MAX_DEGREE   = gbd_pkg::MaxDegree
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gbd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gbd_pkg::out_item_t out_data_o
);
  import gbd_pkg::*;

  logic [5:0] vc_q, live_n;
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 6'd32;
    else if (cfg_we_i) vc_q <= cfg_wdata_i;
  end

  always_comb begin
    live_n = vc_q;
    if ({26'd0, live_n} > MAX_VERTICES) live_n = 6'(MAX_VERTICES);
    if (live_n > 6'd32) live_n = 6'd32;
  end

  gbd_front u_front (
    .clk_i, .rst_ni, .live_n_i(live_n), .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  gbd_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_back (
    .clk_i, .rst_ni, .live_n_i(live_n), .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready), .cmd_i(cmd), .out_valid_o, .out_ready_i,
    .out_data_o
  );
endmodule

@@ design/gbd_front.sv @@
// ---------------------------------------------------------------------------
// Graph engine front end
// Accepts input beats, range-checks them and queues classified commands.
// ---------------------------------------------------------------------------
module gbd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        live_n_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gbd_pkg::in_item_t in_data_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output gbd_pkg::cmd_t     cmd_o
);
  import gbd_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push, pop, a_bad, b_bad, trav;

  always_comb begin
    a_bad = {1'b0, in_data_i.vertex_a} >= live_n_i;
    b_bad = {1'b0, in_data_i.vertex_b} >= live_n_i;
    trav  = (in_data_i.func == FUNC_BFS) || (in_data_i.func == FUNC_DFS);
    cmd_in.func     = in_data_i.func;
    cmd_in.vertex_a = in_data_i.vertex_a;
    cmd_in.vertex_b = in_data_i.vertex_b;
    cmd_in.reject_status = STATUS_OK;
    cmd_in.reject = 1'b0;
    if (trav) begin
      cmd_in.reject = a_bad;
      cmd_in.reject_status = a_bad ? STATUS_RANGE : STATUS_OK;
    end else if (in_data_i.func > FUNC_DFS) begin
      cmd_in.reject = 1'b1;
    end else if (a_bad || b_bad) begin
      cmd_in.reject = 1'b1;
      cmd_in.reject_status = STATUS_RANGE;
    end
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ design/gbd_back.sv @@
// ---------------------------------------------------------------------------
// Graph engine back end
// Executes link commands and traversals over the neighbor memory.
// ---------------------------------------------------------------------------
module gbd_back #(
  parameter int unsigned MAX_VERTICES = gbd_pkg::MaxVertices,
  parameter int unsigned MAX_DEGREE   = gbd_pkg::MaxDegree
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [5:0]         live_n_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  gbd_pkg::cmd_t      cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gbd_pkg::out_item_t out_data_o
);
  import gbd_pkg::*;

  // Vertex ids are five bits wide, so no more than 32 lists are ever used.
  localparam int NV = (MAX_VERTICES > 32) ? 32 : MAX_VERTICES;
  localparam int VW = (NV > 1) ? $clog2(NV) : 1;
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW = $clog2(MAX_DEGREE + 2);
  localparam int MD = NV * (1 << DW);
  localparam int WL = 32;
  localparam int WW = 5;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_ADD_A  = 10'b0000000010,
    ST_ADD_B  = 10'b0000000100,
    ST_SCAN   = 10'b0000001000,
    ST_SHIFT  = 10'b0000010000,
    ST_TPOP   = 10'b0000100000,
    ST_TREAD  = 10'b0001000000,
    ST_TCHECK = 10'b0010000000,
    ST_EMIT   = 10'b0100000000,
    ST_SREAD  = 10'b1000000000
  } state_e;

  state_e state_q;

  logic [4:0]          mem_q [MD];
  logic [4:0]          rdata_q;
  logic                mem_we;
  logic [VW+DW-1:0]    mem_wa, mem_ra;
  logic [4:0]          mem_wd;
  logic [CW-1:0]       count_q [NV];
  logic [NV-1:0]       vis_q;
  logic [4:0]          wl_q [WL];
  logic [5:0]          wcnt_q, head_q;
  cmd_t                cmd_q;
  logic [VW-1:0]       cur_q;
  logic [CW-1:0]       idx_q;
  logic                dfs_q;
  logic                ovalid_q;
  out_item_t           odata_q;
  logic [VW-1:0]       va, vb, adj_v;
  logic [CW-1:0]       cnt_a, cnt_b;
  logic                room, more;

  assign va    = cmd_q.vertex_a[VW-1:0];
  assign vb    = cmd_q.vertex_b[VW-1:0];
  assign cnt_a = count_q[va];
  assign cnt_b = count_q[vb];
  assign adj_v = rdata_q[VW-1:0];
  assign more  = dfs_q ? (wcnt_q != 6'd0) : (head_q < wcnt_q);
  assign cmd_ready_o = (state_q == ST_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    if (va == vb) room = ({1'b0, cnt_a} + (CW+1)'(2)) <= (CW+1)'(MAX_DEGREE);
    else room = (cnt_a < CW'(MAX_DEGREE)) && (cnt_b < CW'(MAX_DEGREE));
  end

  // Memory write port and read address.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {va, cnt_a[DW-1:0]};
    mem_wd = cmd_q.vertex_b;
    mem_ra = {cur_q, idx_q[DW-1:0]};
    unique case (state_q)
      ST_ADD_A: begin mem_we = room; end
      ST_ADD_B: begin
        mem_we = 1'b1; mem_wa = {vb, cnt_b[DW-1:0]}; mem_wd = cmd_q.vertex_a;
      end
      ST_SHIFT: begin
        mem_we = idx_q < cnt_a; mem_wa = {va, idx_q[DW-1:0] - DW'(1)}; mem_wd = rdata_q;
      end
      ST_SREAD, ST_TREAD: begin
        mem_ra = {cur_q, idx_q[DW-1:0] - DW'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      vis_q    <= '0;
      wcnt_q   <= '0;
      head_q   <= '0;
      for (int i = 0; i < NV; i++) count_q[i] <= '0;
      cur_q <= '0; idx_q <= '0; dfs_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (cmd_i.reject) begin
              odata_q  <= '{5'd0, 1'b1, 1'b0, cmd_i.reject_status};
              ovalid_q <= 1'b1;
            end else if (cmd_i.func == FUNC_ADD) begin
              state_q <= ST_ADD_A;
            end else if (cmd_i.func == FUNC_BFS || cmd_i.func == FUNC_DFS) begin
              vis_q <= NV'(1) << cmd_i.vertex_a[VW-1:0];
              wl_q[0] <= cmd_i.vertex_a;
              wcnt_q <= 6'd1; head_q <= '0;
              dfs_q <= cmd_i.func == FUNC_DFS;
              state_q <= ST_TPOP;
            end else begin
              cur_q <= cmd_i.vertex_a[VW-1:0];
              idx_q <= count_q[cmd_i.vertex_a[VW-1:0]];
              state_q <= ST_SREAD;
            end
          end
        end
        ST_ADD_A: begin
          if (!room) begin
            odata_q <= '{5'd0, 1'b1, 1'b0, STATUS_FULL};
            ovalid_q <= 1'b1; state_q <= ST_IDLE;
          end else begin
            count_q[va] <= cnt_a + CW'(1);
            state_q <= ST_ADD_B;
          end
        end
        ST_ADD_B: begin
          count_q[vb] <= cnt_b + CW'(1);
          odata_q <= '{5'd0, 1'b1, 1'b0, STATUS_OK};
          ovalid_q <= 1'b1; state_q <= ST_IDLE;
        end
        // Scan newest first; SREAD issues the read for idx-1 and SCAN checks the data it returns.
        ST_SREAD: begin
          if (idx_q == '0) begin
            odata_q <= '{5'd0, 1'b1, 1'b0, STATUS_OK};
            ovalid_q <= 1'b1; state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q - CW'(1);
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rdata_q == cmd_q.vertex_b) begin
            if (cmd_q.func == FUNC_REMOVE) begin
              idx_q <= idx_q + CW'(1);
              state_q <= ST_TCHECK;
            end else begin
              odata_q <= '{5'd0, 1'b1, 1'b1, STATUS_OK};
              ovalid_q <= 1'b1; state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_SREAD;
          end
        end
        // Shift entries above the hit down by one, one per TCHECK/SHIFT pair.
        ST_SHIFT: begin
          if (idx_q >= cnt_a) begin
            count_q[va] <= cnt_a - CW'(1);
            odata_q <= '{5'd0, 1'b1, 1'b1, STATUS_OK};
            ovalid_q <= 1'b1; state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + CW'(1);
            state_q <= ST_TCHECK;
          end
        end
        ST_TPOP: begin
          if (!ovalid_q) begin
            if (dfs_q) begin
              cur_q <= wl_q[wcnt_q[4:0] - 5'd1][VW-1:0];
              wcnt_q <= wcnt_q - 6'd1;
              odata_q <= '{wl_q[wcnt_q[4:0] - 5'd1], 1'b0, 1'b0, STATUS_OK};
            end else begin
              cur_q <= wl_q[head_q[4:0]][VW-1:0];
              head_q <= head_q + 6'd1;
              odata_q <= '{wl_q[head_q[4:0]], 1'b0, 1'b0, STATUS_OK};
            end
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          idx_q <= count_q[cur_q];
          state_q <= ST_TREAD;
        end
        ST_TREAD: begin
          if (idx_q == '0) begin
            odata_q.last_result <= !more;
            ovalid_q <= 1'b1;
            state_q <= more ? ST_TPOP : ST_IDLE;
          end else begin
            idx_q <= idx_q - CW'(1);
            state_q <= ST_TCHECK;
          end
        end
        ST_TCHECK: begin
          if (cmd_q.func == FUNC_REMOVE) begin
            state_q <= ST_SHIFT;
          end else begin
            if ({1'b0, rdata_q} < live_n_i && !vis_q[adj_v]) begin
              vis_q[adj_v] <= 1'b1;
              if (wcnt_q < 6'(WL)) begin
                wl_q[wcnt_q[WW-1:0]] <= rdata_q;
                wcnt_q <= wcnt_q + 6'd1;
              end
            end
            state_q <= ST_TREAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ design/gbd_checker.sv @@
// ---------------------------------------------------------------------------
// Graph engine port checker
// Port-level checks on the result channel.
// ---------------------------------------------------------------------------
`include "graph_bfs_dfs_engine_unit_assert.svh"
module gbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input gbd_pkg::out_item_t out_data_o
);
  import gbd_pkg::*;
  `GBD_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `GBD_ASSERT_IMP(a_hit_last, clk_i, rst_ni, out_valid_o && out_data_o.link_hit, out_data_o.last_result)
  `GBD_ASSERT_IMP(a_status, clk_i, rst_ni, out_valid_o, out_data_o.status_code != 2'd3)
  `GBD_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status_code != STATUS_OK, out_data_o.visited_vertex == 5'd0)
endmodule

bind graph_bfs_dfs_engine_unit gbd_checker u_gbd_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .out_data_o
);

@@ sim/graph_bfs_dfs_engine_unit_tb.sv @@
// ---------------------------------------------------------------------------
// Graph BFS/DFS engine testbench
// A directed table of link commands, traversals and vertex-count changes runs
// first. Random phases follow under several vertex counts and stall patterns.
// Every beat from the block is checked field by field against a local
// graph model.
// ---------------------------------------------------------------------------
module graph_bfs_dfs_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbd_pkg::*;

  localparam logic [2:0] FUNC_RSV5 = 3'd5;
  localparam logic [2:0] FUNC_RSV6 = 3'd6;
  localparam logic [2:0] FUNC_RSV7 = 3'd7;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 64;

  typedef struct {
    bit         is_cfg;
    logic [5:0] count;
    logic [2:0] func;
    logic [4:0] va;
    logic [4:0] vb;
    bit         fixed;
    out_item_t  res;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  graph_bfs_dfs_engine_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the graph.
  logic [4:0] adj_list [MaxVertices][MaxDegree];
  int unsigned adj_len [MaxVertices];
  bit          seen [MaxVertices];
  int unsigned vcount_reg = 32;

  out_item_t   pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic int unsigned live_n();
    return (vcount_reg > MaxVertices) ? MaxVertices : vcount_reg;
  endfunction

  function automatic out_item_t beat(logic [4:0] v, logic last, logic hit,
                                     logic [1:0] st);
    out_item_t r;
    r.visited_vertex = v;
    r.last_result = last;
    r.link_hit = hit;
    r.status_code = st;
    return r;
  endfunction

  // Applies one command to the local graph and queues the beats it yields.
  task automatic predict_graph_op(in_item_t it);
    int unsigned n, head, wc, cur, w;
    int pos;
    bit dfs;
    logic [4:0] wl [32];
    out_item_t tr[$];
    n = live_n();
    if (it.func == FUNC_BFS || it.func == FUNC_DFS) begin
      if (it.vertex_a >= n) begin
        pending_q.push_back(beat(5'd0, 1'b1, 1'b0, STATUS_RANGE));
        return;
      end
      dfs = (it.func == FUNC_DFS);
      foreach (seen[i]) seen[i] = 1'b0;
      head = 0;
      wc = 0;
      seen[it.vertex_a] = 1'b1;
      wl[wc++] = it.vertex_a;
      while (dfs ? wc > 0 : head < wc) begin
        if (dfs) cur = wl[--wc];
        else cur = wl[head++];
        tr.push_back(beat(cur[4:0], 1'b0, 1'b0, STATUS_OK));
        for (int i = int'(adj_len[cur]) - 1; i >= 0; i--) begin
          w = adj_list[cur][i];
          if (w >= n || seen[w]) continue;
          seen[w] = 1'b1;
          if (wc < 32) wl[wc++] = w[4:0];
        end
      end
      tr[tr.size()-1].last_result = 1'b1;
      foreach (tr[i]) pending_q.push_back(tr[i]);
      return;
    end
    if (it.func > FUNC_DFS) begin
      pending_q.push_back(beat(5'd0, 1'b1, 1'b0, STATUS_OK));
      return;
    end
    if (it.vertex_a >= n || it.vertex_b >= n) begin
      pending_q.push_back(beat(5'd0, 1'b1, 1'b0, STATUS_RANGE));
      return;
    end
    if (it.func == FUNC_ADD) begin
      if ((it.vertex_a == it.vertex_b) ? (adj_len[it.vertex_a] + 2 > MaxDegree)
          : (adj_len[it.vertex_a] >= MaxDegree || adj_len[it.vertex_b] >= MaxDegree))
      begin
        pending_q.push_back(beat(5'd0, 1'b1, 1'b0, STATUS_FULL));
        return;
      end
      adj_list[it.vertex_a][adj_len[it.vertex_a]++] = it.vertex_b;
      adj_list[it.vertex_b][adj_len[it.vertex_b]++] = it.vertex_a;
      pending_q.push_back(beat(5'd0, 1'b1, 1'b0, STATUS_OK));
      return;
    end
    pos = -1;
    for (int i = int'(adj_len[it.vertex_a]) - 1; i >= 0 && pos < 0; i--)
      if (adj_list[it.vertex_a][i] == it.vertex_b) pos = i;
    if (it.func == FUNC_REMOVE && pos >= 0) begin
      for (int i = pos; i + 1 < int'(adj_len[it.vertex_a]); i++)
        adj_list[it.vertex_a][i] = adj_list[it.vertex_a][i+1];
      adj_len[it.vertex_a]--;
    end
    pending_q.push_back(beat(5'd0, 1'b1, pos >= 0, STATUS_OK));
  endtask

  // Drives one command; returns after the beat is taken.
  task automatic send_cmd(in_item_t it, bit fixed, out_item_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = it;
    do @(posedge clk_i); while (!in_ready_o);
    if (fixed) begin
      predict_graph_op(it);
      void'(pending_q.pop_back());
      pending_q.push_back(res);
    end else begin
      predict_graph_op(it);
    end
    @(negedge clk_i);
  endtask

  // Waits for the block to drain, then writes the vertex count.
  task automatic set_vertex_count(logic [5:0] cnt);
    in_valid_i = 1'b0;
    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = cnt;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    vcount_reg = cnt;
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    out_item_t exp_beat;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected beat %h", out_data_o);
        err_cnt++;
      end else begin
        exp_beat = pending_q.pop_front();
        if (out_data_o.visited_vertex !== exp_beat.visited_vertex) begin
          $error("visited_vertex exp %0d got %0d", exp_beat.visited_vertex,
                 out_data_o.visited_vertex);
          err_cnt++;
        end
        if (out_data_o.last_result !== exp_beat.last_result) begin
          $error("last_result exp %0d got %0d", exp_beat.last_result,
                 out_data_o.last_result);
          err_cnt++;
        end
        if (out_data_o.link_hit !== exp_beat.link_hit) begin
          $error("link_hit exp %0d got %0d", exp_beat.link_hit, out_data_o.link_hit);
          err_cnt++;
        end
        if (out_data_o.status_code !== exp_beat.status_code) begin
          $error("status_code exp %0d got %0d", exp_beat.status_code,
                 out_data_o.status_code);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("graph_bfs_dfs_engine_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    stim_row_t   rows[$];
    in_item_t    it;
    logic [5:0]  phase_cnt [6];
    int unsigned n, pool, sel;
    phase_cnt = '{6'd63, 6'd12, 6'd1, 6'd0, 6'd32, 6'd3};
    foreach (adj_len[i]) adj_len[i] = 0;

    // Directed table; typed results only where they are obvious.
    rows.push_back('{0, 0, FUNC_ADD, 0, 1, 0, '0});
    rows.push_back('{0, 0, FUNC_ADD, 0, 31, 0, '0});
    rows.push_back('{0, 0, FUNC_ADD, 31, 31, 0, '0});
    rows.push_back('{0, 0, FUNC_FIND, 0, 1, 0, '0});
    rows.push_back('{0, 0, FUNC_FIND, 1, 2, 0, '0});
    rows.push_back('{0, 0, FUNC_BFS, 1, 0, 0, '0});
    rows.push_back('{0, 0, FUNC_DFS, 1, 0, 0, '0});
    rows.push_back('{0, 0, FUNC_REMOVE, 0, 1, 0, '0});
    rows.push_back('{0, 0, FUNC_REMOVE, 0, 1, 0, '0});
    rows.push_back('{0, 0, FUNC_BFS, 31, 0, 0, '0});
    rows.push_back('{0, 0, FUNC_RSV5, 3, 4, 1, beat(0, 1, 0, STATUS_OK)});
    rows.push_back('{0, 0, FUNC_RSV6, 31, 31, 1, beat(0, 1, 0, STATUS_OK)});
    rows.push_back('{0, 0, FUNC_RSV7, 0, 0, 1, beat(0, 1, 0, STATUS_OK)});
    for (int k = 0; k < 4; k++) rows.push_back('{0, 0, FUNC_ADD, 5, 5, 0, '0});
    rows.push_back('{0, 0, FUNC_ADD, 5, 5, 1, beat(0, 1, 0, STATUS_FULL)});
    rows.push_back('{0, 0, FUNC_ADD, 5, 6, 1, beat(0, 1, 0, STATUS_FULL)});
    rows.push_back('{1, 6'd4, 0, 0, 0, 0, '0});
    rows.push_back('{0, 0, FUNC_ADD, 4, 0, 1, beat(0, 1, 0, STATUS_RANGE)});
    rows.push_back('{0, 0, FUNC_FIND, 0, 31, 1, beat(0, 1, 0, STATUS_RANGE)});
    rows.push_back('{0, 0, FUNC_BFS, 9, 0, 1, beat(0, 1, 0, STATUS_RANGE)});
    rows.push_back('{0, 0, FUNC_DFS, 0, 0, 0, '0});
    rows.push_back('{0, 0, FUNC_FIND, 0, 0, 0, '0});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        set_vertex_count(rows[i].count);
      end else begin
        it.func = rows[i].func;
        it.vertex_a = rows[i].va;
        it.vertex_b = rows[i].vb;
        send_cmd(it, rows[i].fixed, rows[i].res);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_vertex_count(phase_cnt[ph]);
      send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 62 : 0;
      recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 36 : 0;
      n = live_n();
      // A narrow vertex pool fills lists; a wide one spreads the graph.
      pool = ($urandom_range(1) != 0 && n > 4) ? 4 : n;
      for (int k = 0; k < 35; k++) begin
        sel = $urandom_range(99);
        it.func = (sel < 35) ? FUNC_ADD : (sel < 50) ? FUNC_REMOVE :
                  (sel < 65) ? FUNC_FIND : (sel < 80) ? FUNC_BFS :
                  (sel < 94) ? FUNC_DFS : 3'($urandom_range(5, 7));
        if (pool == 0 || $urandom_range(99) < 12) begin
          it.vertex_a = 5'($urandom);
          it.vertex_b = 5'($urandom);
        end else begin
          it.vertex_a = 5'($urandom_range(pool - 1));
          it.vertex_b = 5'($urandom_range(pool - 1));
        end
        send_cmd(it, 1'b0, '0);
      end
    end

    in_valid_i = 1'b0;
    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("graph_bfs_dfs_engine_unit_tb: done, clean");
    end else begin
      $display("graph_bfs_dfs_engine_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
